FILE: src/base64_stream_decoder_assert.svh
// Assertion helpers for the base64 stream decoder.
// Each macro checks on the rising edge of i_clk and stays quiet while reset is applied.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication.
`define B64D_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_CHAR   = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

    // One input item.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       end_of_stream;
    } t_in;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        t_status    status;
        logic       last_of_run;
    } t_out;

    // An input item causes at most this many results.
    localparam int unsigned NUM_SLOTS = 3;

    // A group of results caused by one input item. The last used slot has
    // last_of_run set, which also marks the end of the group.
    typedef struct packed {
        t_out [NUM_SLOTS-1:0] res;
    } t_job;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

endpackage

`default_nettype wire

FILE: src/b64d_front.sv
`default_nettype none

module b64d_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  b64d_pkg::t_in  i_item,
    output logic           o_job_valid,
    output b64d_pkg::t_job o_job
);
    import b64d_pkg::*;

    // Returns {valid, sextet}.
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    function automatic logic [7:0] byte_a(input logic [5:0] s0, input logic [5:0] s1);
        return {s0, s1[5:4]};
    endfunction

    function automatic logic [7:0] byte_b(input logic [5:0] s1, input logic [5:0] s2);
        return {s1[3:0], s2[5:2]};
    endfunction

    function automatic logic [7:0] byte_c(input logic [5:0] s2, input logic [5:0] s3);
        return {s2[1:0], s3};
    endfunction

    logic [5:0] r_store [NUM_SLOTS];
    logic [5:0] n_store [NUM_SLOTS];
    logic [1:0] r_count, n_count;
    logic       r_seen, n_seen;
    logic       r_err, n_err;
    logic [6:0] mapped;
    logic [1:0] nres;
    t_job       job;

    assign mapped = map_char(i_item.char_byte);

    always_comb begin
        n_store = r_store;
        n_count = r_count;
        n_seen  = r_seen;
        n_err   = r_err;
        job     = '0;
        nres    = 2'd0;

        // Character first: store a sextet, finish a quartet, or flag an error.
        if (i_item.has_char && !r_err) begin
            n_seen = 1'b1;
            if (!mapped[6]) begin
                n_err              = 1'b1;
                job.res[0].status  = ST_BAD_CHAR;
                nres               = 2'd1;
            end else if (r_count == 2'd3) begin
                job.res[0].out_byte   = byte_a(r_store[0], r_store[1]);
                job.res[0].byte_valid = 1'b1;
                job.res[1].out_byte   = byte_b(r_store[1], r_store[2]);
                job.res[1].byte_valid = 1'b1;
                job.res[2].out_byte   = byte_c(r_store[2], mapped[5:0]);
                job.res[2].byte_valid = 1'b1;
                nres                  = 2'd3;
                n_count               = 2'd0;
            end else begin
                n_store[r_count] = mapped[5:0];
                n_count          = r_count + 2'd1;
            end
        end

        // Then the flush. A finished quartet leaves nothing held, so the two
        // parts never both produce results.
        if (i_item.end_of_stream) begin
            if (!n_err) begin
                if (!n_seen) begin
                    job.res[0].status = ST_EMPTY;
                    nres              = 2'd1;
                end else begin
                    unique case (n_count)
                        2'd1: begin
                            job.res[0].status = ST_BAD_LENGTH;
                            nres              = 2'd1;
                        end
                        2'd2: begin
                            job.res[0].out_byte   = byte_a(n_store[0], n_store[1]);
                            job.res[0].byte_valid = 1'b1;
                            nres                  = 2'd1;
                        end
                        2'd3: begin
                            job.res[0].out_byte   = byte_a(n_store[0], n_store[1]);
                            job.res[0].byte_valid = 1'b1;
                            job.res[1].out_byte   = byte_b(n_store[1], n_store[2]);
                            job.res[1].byte_valid = 1'b1;
                            nres                  = 2'd2;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            n_count = 2'd0;
            n_seen  = 1'b0;
            n_err   = 1'b0;
        end

        unique case (nres)
            2'd1:    job.res[0].last_of_run = 1'b1;
            2'd2:    job.res[1].last_of_run = 1'b1;
            2'd3:    job.res[2].last_of_run = 1'b1;
            default: begin
            end
        endcase
    end

    assign o_job_valid = i_accept && (nres != 2'd0);
    assign o_job       = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_seen  <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_seen  <= n_seen;
            r_err   <= n_err;
        end
    end

    // Sextets are only read below the fill count, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_store <= n_store;
        end
    end

endmodule

`default_nettype wire

FILE: src/b64d_queue.sv
`default_nettype none

module b64d_queue #(
    parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output b64d_pkg::t_job o_data,
    output logic           o_empty
);
    import b64d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/b64d_back.sv
`default_nettype none

module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_avail,
    input  b64d_pkg::t_job i_job,
    output logic           o_job_take,
    input  logic           i_pop,
    output logic           o_empty,
    output b64d_pkg::t_out o_result
);
    import b64d_pkg::*;

    t_job       r_job;
    logic [1:0] r_idx;
    logic       r_busy;
    t_out       cur;
    logic       last;

    assign cur        = r_job.res[r_idx];
    assign last       = cur.last_of_run;
    assign o_empty    = !r_busy;
    assign o_result   = cur;
    // Load the next group when idle or as the final item of this group leaves.
    assign o_job_take = i_job_avail && (!r_busy || (i_pop && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_job_take) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (r_busy && i_pop) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
        end
    end

endmodule

`default_nettype wire

FILE: src/base64_stream_decoder.sv
// Channel  | Ports                        | Handshake
// ---------+------------------------------+------------------------------------
// input    | i_item, i_push, o_full       | item taken when i_push && !o_full
// result   | o_result, o_empty, i_pop     | item taken when i_pop && !o_empty
//
// One input item is taken every cycle while the job queue has room. An item is
// decoded in the cycle it is taken and its results (up to three) are written
// into the queue as one group at the accepting edge. The back end loads the
// group when it is idle or as the final result of its current group is taken;
// from that load on, the group's first result is on the result ports.
// While i_pop is high and groups are queued, the result side delivers one item
// per cycle, across group boundaries too, enough for three bytes per quartet.
// Reset is synchronous and active low; it empties the queue and clears the
// decoder state at once, with no clearing pass. o_full rises only when the
// queue holds QUEUE_DEPTH groups that the result side has not yet drained.
`default_nettype none
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_in  i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output b64d_pkg::t_out o_result
);
    import b64d_pkg::*;

    // The front end maps each character to a sextet, tracks the quartet and the
    // stream flags, and packs whatever results the item causes into one group.
    logic q_push, q_pop, q_full, q_empty;
    logic accept;
    t_job job_in, job_out;
    logic job_has_last;
    logic res_is_status;
    logic status_alone;

    assign accept = i_push && !q_full;
    assign o_full = q_full;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_job_valid (q_push),
        .o_job       (job_in)
    );

    // The queue decouples decoding from delivery, so a stalled reader does not
    // hold up the input until the queue has filled.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    // The back end walks through each group one result item at a time.
    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_avail (!q_empty),
        .i_job       (job_out),
        .o_job_take  (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (o_result)
    );

    assign job_has_last  = job_in.res[0].last_of_run || job_in.res[1].last_of_run
                           || job_in.res[2].last_of_run;
    assign res_is_status = !o_empty && (o_result.status != ST_OK);
    assign status_alone  = o_result.last_of_run && !o_result.byte_valid;

    // A group is only written while the queue has room.
    `B64D_ASSERT_IMPL(a_no_push_when_full, q_full, !q_push, "group pushed into a full queue")
    // Every group carries an end marker, or the back end would run into stale slots.
    `B64D_ASSERT_IMPL(a_group_has_last, q_push, job_has_last, "group without a final result")
    // A group taken from the queue shows up on the result side in the next cycle.
    `B64D_ASSERT_NEXT(a_take_shows, q_pop, !o_empty, "taken group not presented")
    // A status result stands alone, so it always closes its run.
    `B64D_ASSERT_IMPL(a_status_is_last, res_is_status, status_alone, "status result not alone")

endmodule

`default_nettype wire
